[design/fat12cw_pkg.sv]
// shared types and constants for the fat12 cluster chain walker
package fat12cw_pkg;

    localparam int TABLE_BYTES = 8192;
    localparam int MAX_RUN     = 64;

    localparam int ADDR_W = $clog2(TABLE_BYTES);
    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam int CL_W   = 12;
    localparam int BADDR_W = 13;
    localparam int LIM_W  = 14;

    localparam logic [CL_W-1:0]  END_MARK  = 12'hFF8;
    localparam logic [7:0]       NIBBLE    = 8'h0f;
    localparam logic [LIM_W-1:0] LIM_RESET = 14'd8192;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CONT  = 2'd2;

    typedef struct packed {
        logic [CL_W-1:0] cluster;
        logic            cluster_valid;
        logic            chain_done;
        logic            out_of_range;
        logic            last;
    } t_res;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

endpackage

[design/fat12cw_ram.sv]
// generic single write port ram with registered read
module fat12cw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/fat12cw_walker.sv]
// item decode and chain walk sequencer around one shared index adder
module fat12cw_walker
    import fat12cw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [BADDR_W-1:0] i_byte_address,
    input  logic [7:0]         i_byte_value,
    input  logic [CL_W-1:0]    i_start_cluster,
    input  logic [LIM_W-1:0]   i_limit,
    input  logic               i_room,
    output t_ram_wr            o_wr,
    output logic [ADDR_W-1:0]  o_rd_addr,
    input  logic [7:0]         i_rd_data,
    output logic               o_push,
    output t_res               o_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_RD1    = 3'd2;
    localparam logic [2:0] S_RD2    = 3'd3;
    localparam logic [2:0] S_CAP    = 3'd4;
    localparam logic [2:0] S_ERR    = 3'd5;
    localparam logic [2:0] S_NOWALK = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CL_W-1:0]    r_cursor, n_cursor;
    logic               r_active, n_active;
    logic [RUN_W-1:0]   r_n, n_n;
    logic               r_pend_v, n_pend_v;
    logic [CL_W-1:0]    r_pend_c, n_pend_c;
    logic [BADDR_W-1:0] r_idx, n_idx;
    logic [7:0]         r_lo, n_lo;

    logic               accept;
    logic [LIM_W-1:0]   three_c;
    logic [BADDR_W-1:0] idx;
    logic [LIM_W-1:0]   idx_p1;
    logic               oor;
    logic               marker;
    logic               cap_near;
    logic [CL_W-1:0]    next_c;
    logic [7:0]         hi_masked;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // shared unit: byte index 3c/2 and its range check
    assign three_c  = {1'b0, r_cursor, 1'b0} + {2'b00, r_cursor};
    assign idx      = three_c[LIM_W-1:1];
    assign idx_p1   = {1'b0, idx} + LIM_W'(1);
    assign oor      = (idx_p1 >= i_limit);
    assign marker   = (r_cursor >= END_MARK);
    assign cap_near = (r_n >= RUN_W'(MAX_RUN - 1));

    // packed 12-bit entry from the two table bytes
    assign hi_masked = i_rd_data & NIBBLE;
    assign next_c = r_pend_c[0] ? {i_rd_data, r_lo[7:4]} : {hi_masked[3:0], r_lo};

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_active = r_active;
        n_n      = r_n;
        n_pend_v = r_pend_v;
        n_pend_c = r_pend_c;
        n_idx    = r_idx;
        n_lo     = r_lo;
        o_push   = 1'b0;
        o_res    = '0;
        o_wr.en   = 1'b0;
        o_wr.addr = i_byte_address[ADDR_W-1:0];
        o_wr.data = i_byte_value;
        o_rd_addr = idx[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_LOAD: begin
                            o_wr.en = ({1'b0, i_byte_address} < LIM_W'(TABLE_BYTES));
                        end
                        KIND_START: begin
                            n_cursor = i_start_cluster;
                            n_active = 1'b1;
                            n_n      = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_CHECK;
                        end
                        KIND_CONT: begin
                            n_n      = '0;
                            n_pend_v = 1'b0;
                            n_state  = r_active ? S_CHECK : S_NOWALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (marker) begin
                    if (r_pend_v) begin
                        if (i_room) begin
                            o_push = 1'b1;
                            o_res  = '{r_pend_c, 1'b1, 1'b0, 1'b0, 1'b0};
                            n_pend_v = 1'b0;
                        end
                    end else if (i_room) begin
                        o_push = 1'b1;
                        o_res  = '{r_cursor, 1'b0, 1'b1, 1'b0, 1'b1};
                        n_active = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else if (oor) begin
                    if (cap_near) begin
                        // no room for member plus error: close the run on the pending member
                        if (i_room) begin
                            o_push = 1'b1;
                            o_res  = '{r_pend_c, 1'b1, 1'b0, 1'b0, 1'b1};
                            n_pend_v = 1'b0;
                            n_state  = S_IDLE;
                        end
                    end else if (r_pend_v) begin
                        if (i_room) begin
                            o_push = 1'b1;
                            o_res  = '{r_pend_c, 1'b1, 1'b0, 1'b0, 1'b0};
                            n_pend_v = 1'b0;
                        end
                    end else if (i_room) begin
                        o_push = 1'b1;
                        o_res  = '{r_cursor, 1'b1, 1'b0, 1'b0, 1'b0};
                        n_n     = r_n + RUN_W'(1);
                        n_state = S_ERR;
                    end
                end else begin
                    if (r_pend_v) begin
                        if (i_room) begin
                            o_push = 1'b1;
                            o_res  = '{r_pend_c, 1'b1, 1'b0, 1'b0, 1'b0};
                            n_pend_v = 1'b0;
                        end
                    end else begin
                        // member held back until we know whether it ends the item
                        n_pend_v = 1'b1;
                        n_pend_c = r_cursor;
                        n_n      = r_n + RUN_W'(1);
                        n_idx    = idx;
                        n_state  = S_RD1;
                    end
                end
            end
            S_RD1: begin
                n_lo      = i_rd_data;
                o_rd_addr = ADDR_W'(r_idx + BADDR_W'(1));
                n_state   = S_RD2;
            end
            S_RD2: begin
                n_cursor = next_c;
                n_state  = (r_n == RUN_W'(MAX_RUN)) ? S_CAP : S_CHECK;
            end
            S_CAP: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_res  = '{r_pend_c, 1'b1, 1'b0, 1'b0, 1'b1};
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_ERR: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_res  = '{r_cursor, 1'b0, 1'b1, 1'b1, 1'b1};
                    n_active = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_NOWALK: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_res  = '{{CL_W{1'b0}}, 1'b0, 1'b1, 1'b0, 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_active <= 1'b0;
            r_n      <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_active <= n_active;
            r_n      <= n_n;
            r_pend_v <= n_pend_v;
        end
        r_pend_c <= n_pend_c;
        r_idx    <= n_idx;
        r_lo     <= n_lo;
    end

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_room)
        else $error("result pushed into a full output stage");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RUN_W'(MAX_RUN))
        else $error("run count beyond cap");

    a_member_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.cluster_valid) |-> !o_res.chain_done && !o_res.out_of_range)
        else $error("chain member flagged as done");

    a_read_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD2) |-> r_pend_v)
        else $error("entry read without a pending member");

    a_walk_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_START)) |=> (r_state == S_CHECK))
        else $error("start item did not begin a walk");

endmodule

[design/fat12_cluster_chain_walker_top.sv]
// top level: config register, table ram, walk sequencer and output register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_stall  | i_kind, i_byte_address, i_byte_value,
//          |           |                    | i_start_cluster
//  output  | out       | o_valid / i_stall  | o_cluster, o_cluster_valid, o_chain_done,
//          |           |                    | o_out_of_range, o_last
//  config  | in        | i_cfg_we           | i_cfg_data (table bytes in use)
//
// a load item is written to the ram as it is taken; a walk item goes through, per chain link,
// the index/range check, two reads of the single ram read port and entry assembly,
// up to MAX_RUN links, plus a push for each marker or error result
// reset is synchronous active low; the table ram is not cleared, no clearing pass
// output stall holds the walk in place; a new item is taken while the last result waits
module fat12_cluster_chain_walker_top
    import fat12cw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [BADDR_W-1:0] i_byte_address,
    input  logic [7:0]         i_byte_value,
    input  logic [CL_W-1:0]    i_start_cluster,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CL_W-1:0]    o_cluster,
    output logic               o_cluster_valid,
    output logic               o_chain_done,
    output logic               o_out_of_range,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [LIM_W-1:0]   i_cfg_data
);

    logic [LIM_W-1:0]  r_limit, n_limit;
    logic              r_out_v, n_out_v;
    t_res              r_out;
    t_ram_wr           wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              room;
    logic              push;
    t_res              res;

    // bytes in use above the table size act as the table size
    assign n_limit = (i_cfg_data > LIM_W'(TABLE_BYTES)) ? LIM_W'(TABLE_BYTES) : i_cfg_data;

    assign room    = !r_out_v || !i_stall;
    assign n_out_v = push || (r_out_v && i_stall);

    fat12cw_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_BYTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    fat12cw_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_byte_address  (i_byte_address),
        .i_byte_value    (i_byte_value),
        .i_start_cluster (i_start_cluster),
        .i_limit         (r_limit),
        .i_room          (room),
        .o_wr            (wr),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_push          (push),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_RESET;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= n_limit;
            end
            r_out_v <= n_out_v;
        end
        if (push) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_v;
    assign o_cluster       = r_out.cluster;
    assign o_cluster_valid = r_out.cluster_valid;
    assign o_chain_done    = r_out.chain_done;
    assign o_out_of_range  = r_out.out_of_range;
    assign o_last          = r_out.last;

endmodule

[tb/fat12cw_chain_checker.sv]
// chain checker: watches both channels and the config port, predicts each walk and compares
`timescale 1ns / 1ps
module fat12cw_chain_checker
    import fat12cw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [BADDR_W-1:0] i_byte_address,
    input  logic [7:0]         i_byte_value,
    input  logic [CL_W-1:0]    i_start_cluster,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [CL_W-1:0]    o_cluster,
    input  logic               o_cluster_valid,
    input  logic               o_chain_done,
    input  logic               o_out_of_range,
    input  logic               o_last,
    input  logic               i_cfg_we,
    input  logic [LIM_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [7:0]       table_img [TABLE_BYTES];
    logic [CL_W-1:0]  cursor;
    logic             walking;
    logic [LIM_W-1:0] bytes_in_use;
    t_res             expected_links [$];
    int               mismatches = 0;

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic note_result(input logic [CL_W-1:0] cl, input logic member,
                               input logic done, input logic oor);
        t_res r;
        r.cluster       = cl;
        r.cluster_valid = member;
        r.chain_done    = done;
        r.out_of_range  = oor;
        r.last          = 1'b0;
        expected_links.push_back(r);
    endtask

    task automatic tag_last();
        t_res tail;
        tail = expected_links.pop_back();
        tail.last = 1'b1;
        expected_links.push_back(tail);
    endtask

    // follow packed 12-bit entries from the cursor, at most MAX_RUN results per item
    task automatic walk_chain();
        int              n;
        int              idx;
        int              lim;
        logic [CL_W-1:0] c;
        logic [7:0]      lo;
        logic [7:0]      hi;
        lim = (bytes_in_use > TABLE_BYTES) ? TABLE_BYTES : int'(bytes_in_use);
        n = 0;
        while (n < MAX_RUN) begin
            c = cursor;
            if (c >= END_MARK) begin
                note_result(c, 1'b0, 1'b1, 1'b0);
                n++;
                walking = 1'b0;
                break;
            end
            idx = (3 * int'(c)) >> 1;
            if (idx + 1 >= lim) begin
                // member and error must fit in the same run
                if (n + 2 > MAX_RUN) break;
                note_result(c, 1'b1, 1'b0, 1'b0);
                note_result(c, 1'b0, 1'b1, 1'b1);
                n += 2;
                walking = 1'b0;
                break;
            end
            lo = table_img[idx];
            hi = table_img[idx + 1];
            note_result(c, 1'b1, 1'b0, 1'b0);
            n++;
            cursor = c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
        end
        if (n > 0) tag_last();
    endtask

    task automatic take_item();
        case (i_kind)
            KIND_LOAD: begin
                table_img[i_byte_address] = i_byte_value;
            end
            KIND_START: begin
                cursor  = i_start_cluster;
                walking = 1'b1;
                walk_chain();
            end
            KIND_CONT: begin
                if (!walking) begin
                    note_result('0, 1'b0, 1'b1, 1'b0);
                    tag_last();
                end else begin
                    walk_chain();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_res want;
        if (expected_links.size() == 0) begin
            log_mismatch($sformatf("result cluster %03h with none expected", o_cluster));
            return;
        end
        want = expected_links.pop_front();
        if (o_cluster !== want.cluster || o_cluster_valid !== want.cluster_valid ||
            o_chain_done !== want.chain_done || o_out_of_range !== want.out_of_range ||
            o_last !== want.last) begin
            log_mismatch($sformatf("got %03h v%0b d%0b r%0b l%0b, want %03h v%0b d%0b r%0b l%0b",
                o_cluster, o_cluster_valid, o_chain_done, o_out_of_range, o_last,
                want.cluster, want.cluster_valid, want.chain_done, want.out_of_range,
                want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cursor       = '0;
            walking      = 1'b0;
            bytes_in_use = LIM_RESET;
            expected_links.delete();
        end else begin
            if (i_cfg_we) bytes_in_use = i_cfg_data;
            if (i_valid && !o_stall) take_item();
            if (o_valid && !i_stall) check_result();
        end
        o_pending    <= expected_links.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/tb.sv]
// testbench top: clock, reset, stimulus for the chain walker and the final verdict
`timescale 1ns / 1ps
module tb;
    import fat12cw_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NCL          = 128;       // clusters whose entries are always written
    localparam int REGION_BYTES = 192;       // table bytes holding those entries
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 16;
    localparam int DRAIN_WAIT   = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 34;
    localparam longint TIME_LIMIT = 64'd20_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [1:0]         i_kind = KIND_LOAD;
    logic [BADDR_W-1:0] i_byte_address = '0;
    logic [7:0]         i_byte_value = '0;
    logic [CL_W-1:0]    i_start_cluster = '0;
    logic               i_stall = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [LIM_W-1:0]   i_cfg_data = LIM_RESET;
    logic               o_stall;
    logic               o_valid;
    logic [CL_W-1:0]    o_cluster;
    logic               o_cluster_valid;
    logic               o_chain_done;
    logic               o_out_of_range;
    logic               o_last;
    int                 fail_count;
    int                 pending;

    // image of the table region, used to compose load items
    logic [7:0]       table_plan [REGION_BYTES];
    logic [LIM_W-1:0] cur_limit = LIM_RESET;
    bit               tx_idle = 1'b1;
    bit               rx_idle = 1'b1;
    int               items_sent = 0;
    int               hold_asks = 0;

    fat12_cluster_chain_walker_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_byte_address(i_byte_address),
        .i_byte_value(i_byte_value), .i_start_cluster(i_start_cluster),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cluster(o_cluster), .o_cluster_valid(o_cluster_valid),
        .o_chain_done(o_chain_done), .o_out_of_range(o_out_of_range), .o_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    fat12cw_chain_checker link_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_byte_address(i_byte_address),
        .i_byte_value(i_byte_value), .i_start_cluster(i_start_cluster),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cluster(o_cluster), .o_cluster_valid(o_cluster_valid),
        .o_chain_done(o_chain_done), .o_out_of_range(o_out_of_range), .o_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(TIME_LIMIT);
        $display("FAIL fat12_cluster_chain_walker_top");
        $finish;
    end

    // receiver: random stall bursts, plus a long hold when one is asked for
    initial begin
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_asks) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [CL_W-1:0] pick_link();
        if ($urandom_range(0, 5) == 0) return END_MARK + CL_W'($urandom_range(0, 7));
        return CL_W'($urandom_range(0, NCL - 1));
    endfunction

    // write one 12-bit entry into the image, keeping the neighbor's nibble
    function automatic void place_link(input int c, input logic [CL_W-1:0] v);
        int idx;
        idx = (3 * c) >> 1;
        if (c % 2 == 1) begin
            table_plan[idx][7:4] = v[3:0];
            table_plan[idx + 1]  = v[11:4];
        end else begin
            table_plan[idx]           = v[7:0];
            table_plan[idx + 1][3:0]  = v[11:8];
        end
    endfunction

    task automatic offer(input logic [1:0] kind, input logic [BADDR_W-1:0] addr,
                         input logic [7:0] val, input logic [CL_W-1:0] start);
        int gap;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_byte_address  <= addr;
        i_byte_value    <= val;
        i_start_cluster <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic load_byte(input logic [BADDR_W-1:0] addr, input logic [7:0] val);
        offer(KIND_LOAD, addr, val, CL_W'($urandom));
    endtask

    task automatic send_start(input logic [CL_W-1:0] c);
        offer(KIND_START, BADDR_W'($urandom), 8'($urandom), c);
    endtask

    task automatic send_cont();
        offer(KIND_CONT, BADDR_W'($urandom), 8'($urandom), CL_W'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        wait_drained();
        // a trailing load may still be in flight
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_limit = v;
    endtask

    task automatic random_step();
        int r;
        int n;
        int c;
        int idx;
        int lim;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            send_start(CL_W'($urandom_range(0, NCL - 1)));
            n = $urandom_range(0, 3);
            repeat (n) send_cont();
        end else if (r < 65) begin
            c = $urandom_range(0, NCL - 1);
            idx = (3 * c) >> 1;
            place_link(c, pick_link());
            load_byte(BADDR_W'(idx), table_plan[idx]);
            load_byte(BADDR_W'(idx + 1), table_plan[idx + 1]);
        end else if (r < 75) begin
            load_byte(BADDR_W'($urandom_range(REGION_BYTES, TABLE_BYTES - 1)), 8'($urandom));
        end else if (r < 82) begin
            send_cont();
        end else if (r < 88) begin
            send_start(END_MARK + CL_W'($urandom_range(0, 7)));
        end else if (r < 93) begin
            offer(KIND_UNUSED, BADDR_W'($urandom), 8'($urandom), CL_W'($urandom));
        end else begin
            // any cluster, as long as the walk cannot touch an unwritten byte
            lim = (cur_limit > TABLE_BYTES) ? TABLE_BYTES : int'(cur_limit);
            c = $urandom_range(0, (1 << CL_W) - 1);
            if (c < END_MARK && c >= NCL && ((3 * c) >> 1) + 1 < lim)
                c = $urandom_range(0, NCL - 1);
            send_start(CL_W'(c));
        end
    endtask

    initial begin
        int goal;
        int lim;
        bit paused_once;
        paused_once = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // continue with no walk active
        send_cont();

        // fill the region; clusters 0..63 form a straight chain into cluster 100
        for (int c = 0; c < NCL; c++) place_link(c, pick_link());
        for (int c = 0; c < 63; c++) place_link(c, CL_W'(c + 1));
        place_link(63, CL_W'(100));
        for (int a = 0; a < REGION_BYTES; a++) load_byte(BADDR_W'(a), table_plan[a]);

        send_start(12'hFFF);
        send_start(END_MARK);
        send_start('0);            // hits the run cap
        send_cont();
        send_start(CL_W'(10));     // dropped mid-walk by the next start
        send_start(CL_W'(11));
        send_cont();
        send_cont();
        offer(KIND_UNUSED, '1, '1, '1);
        load_byte(BADDR_W'(TABLE_BYTES - 1), 8'hFF);
        load_byte(BADDR_W'(REGION_BYTES), 8'h00);

        // one slot left when the range error comes, member moves to the continue
        write_limit(LIM_W'(100));
        send_start(CL_W'(1));
        send_cont();
        send_cont();

        write_limit('0);
        send_start('0);
        send_start(CL_W'(2048));
        send_start(12'hFFF);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: lim = 16383;
                1: lim = 250;
                2: lim = TABLE_BYTES;
                3: lim = REGION_BYTES;
                4: lim = REGION_BYTES - 1;
                default: lim = $urandom_range(1, 400);
            endcase
            write_limit(LIM_W'(lim));
            tx_idle = (p != 2) && (p != PHASES - 1);
            rx_idle = (p != 3) && (p != PHASES - 1);
            // output held off while items keep coming
            if (p == 0) hold_asks++;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if (p == 2 && !paused_once && items_sent >= goal - PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused_once = 1'b1;
                end
                random_step();
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS fat12_cluster_chain_walker_top");
        end else begin
            $display("FAIL fat12_cluster_chain_walker_top");
        end
        $finish;
    end

endmodule
